// File: rtl/olist_pkg.sv
// ----------------------------------------------------------------------------
// olist_pkg
// Shared widths, command codes and status codes of the ordered list engine.
// ----------------------------------------------------------------------------
package olist_pkg;

  localparam int unsigned DEFAULT_CAPACITY = 16;

  localparam int unsigned CMD_W   = 4;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned POS_W   = 8;
  localparam int unsigned COUNT_W = 9;
  localparam int unsigned STAT_W  = 3;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_FRONT = 4'd0,
    CMD_PUSH_BACK  = 4'd1,
    CMD_POP_FRONT  = 4'd2,
    CMD_POP_BACK   = 4'd3,
    CMD_INSERT     = 4'd4,
    CMD_REMOVE     = 4'd5,
    CMD_FIND       = 4'd6,
    CMD_CLEAR      = 4'd7,
    CMD_READ_ENDS  = 4'd8
  } cmd_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK       = 3'd0,
    STAT_EMPTY    = 3'd1,
    STAT_FULL     = 3'd2,
    STAT_RANGE    = 3'd3,
    STAT_NOTFOUND = 3'd4
  } status_e;

endpackage

// File: rtl/olist_if.sv
// ----------------------------------------------------------------------------
// olist_if
// Valid/ready channels of the ordered list engine: command and result.
// ----------------------------------------------------------------------------
interface olist_req_if;
  import olist_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [CMD_W-1:0]          cmd;
  logic signed [VALUE_W-1:0] value;
  logic [POS_W-1:0]          position;

  modport source (output valid, cmd, value, position, input ready);
  modport sink   (input valid, cmd, value, position, output ready);
endinterface

interface olist_rsp_if;
  import olist_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] result_value;
  logic signed [VALUE_W-1:0] back_value;
  logic [COUNT_W-1:0]        found_index;
  logic [STAT_W-1:0]         status;
  logic [COUNT_W-1:0]        count;

  modport source (output valid, result_value, back_value, found_index, status, count,
                  input ready);
  modport sink   (input valid, result_value, back_value, found_index, status, count,
                  output ready);
endinterface

// File: rtl/ordered_list_engine.sv
// ----------------------------------------------------------------------------
// ordered_list_engine
// Bounded ordered list of signed 32-bit values with push, pop, insert,
// remove, find, clear and end reads.
// ----------------------------------------------------------------------------
// Usage: one command is taken on req_i per transfer (valid and ready high);
// every command gives exactly one result on rsp_o. req_i.ready is high only
// while the engine is idle, so commands are worked on one at a time.
// Entries sit in a single-port-write, single-port-read memory with a
// registered read; all data movement goes through that one port pair.
// Command flow: clear, failed commands and unused codes go straight to the
// finish step; push/insert shift the entries from the position on up one
// slot, then write the new value; pop/remove read the entry, then shift the
// entries behind it down one slot; find compares entries from index 0 until
// a hit or the last entry; read_ends reads the first and the last entry.
// Shifts and find move one entry per cycle, each as a single
// walk through the memory port. The next command is taken once the result
// is in the output register, even if the receiver has not yet taken it; a
// finished command waits while that register is still occupied.
// Reset empties the list at once (the count goes to zero, no memory sweep).
// ----------------------------------------------------------------------------
module ordered_list_engine #(
  parameter int unsigned CAPACITY = olist_pkg::DEFAULT_CAPACITY
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  olist_req_if.sink   req_i,
  olist_rsp_if.source rsp_o
);
  import olist_pkg::*;

  localparam int unsigned IDX_W = $clog2(CAPACITY);
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_SHIFT,
    S_DRAIN,
    S_INS_WR,
    S_TAKE_RD,
    S_TAKE_CAP,
    S_FIND,
    S_FIND_LAST,
    S_ENDS_A,
    S_ENDS_B,
    S_ENDS_C,
    S_FINISH
  } state_e;

  state_e              state_q;
  cmd_e                cmd_q;
  logic [VALUE_W-1:0]  val_q;
  logic [CNT_W-1:0]    cnt_q;
  logic [IDX_W-1:0]    idx_q;
  logic [IDX_W-1:0]    tpos_q;
  logic [IDX_W-1:0]    pend_addr_q;
  logic                pend_q;
  logic                dir_up_q;

  logic [VALUE_W-1:0]  res_val_q;
  logic [VALUE_W-1:0]  res_back_q;
  logic [COUNT_W-1:0]  res_fi_q;
  status_e             res_st_q;

  logic                out_valid_q;
  logic [VALUE_W-1:0]  out_val_q;
  logic [VALUE_W-1:0]  out_back_q;
  logic [COUNT_W-1:0]  out_fi_q;
  status_e             out_st_q;
  logic [COUNT_W-1:0]  out_cnt_q;

  logic [VALUE_W-1:0]  mem [CAPACITY];
  logic [VALUE_W-1:0]  rd_q;
  logic [IDX_W-1:0]    raddr;
  logic [IDX_W-1:0]    waddr;
  logic [VALUE_W-1:0]  wdata;
  logic                we;

  cmd_e                req_cmd;
  logic                full;
  logic                empty;
  logic [IDX_W-1:0]    ins_pos;
  logic [IDX_W-1:0]    last_idx;
  logic                pos_in_range;
  logic                shift_last;

  assign req_cmd      = cmd_e'(req_i.cmd);
  assign full         = (cnt_q == CNT_W'(CAPACITY));
  assign empty        = (cnt_q == '0);
  assign last_idx     = IDX_W'(cnt_q - CNT_W'(1));
  assign pos_in_range = (COUNT_W'(req_i.position) < COUNT_W'(cnt_q));
  assign shift_last   = dir_up_q ? (idx_q == tpos_q) : (idx_q == last_idx);

  always_comb begin
    case (req_cmd)
      CMD_PUSH_FRONT: ins_pos = '0;
      CMD_PUSH_BACK:  ins_pos = IDX_W'(cnt_q);
      default: begin
        ins_pos = pos_in_range ? IDX_W'(req_i.position) : IDX_W'(cnt_q);
      end
    endcase
  end

  // memory port control
  always_comb begin
    raddr = idx_q;
    we    = 1'b0;
    waddr = pend_addr_q;
    wdata = rd_q;
    case (state_q)
      S_SHIFT:   we = pend_q;
      S_DRAIN:   we = 1'b1;
      S_INS_WR: begin
        we    = 1'b1;
        waddr = tpos_q;
        wdata = val_q;
      end
      S_TAKE_RD: raddr = tpos_q;
      S_ENDS_A:  raddr = '0;
      S_ENDS_B:  raddr = last_idx;
      default:   raddr = idx_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_q <= mem[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cmd_q       <= CMD_CLEAR;
      val_q       <= '0;
      cnt_q       <= '0;
      idx_q       <= '0;
      tpos_q      <= '0;
      pend_addr_q <= '0;
      pend_q      <= 1'b0;
      dir_up_q    <= 1'b0;
      res_val_q   <= '0;
      res_back_q  <= '0;
      res_fi_q    <= '0;
      res_st_q    <= STAT_OK;
      out_valid_q <= 1'b0;
      out_val_q   <= '0;
      out_back_q  <= '0;
      out_fi_q    <= '0;
      out_st_q    <= STAT_OK;
      out_cnt_q   <= '0;
    end else begin
      // the finish step reloads the output register itself
      if (out_valid_q && rsp_o.ready && (state_q != S_FINISH)) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (req_i.valid) begin
            cmd_q      <= req_cmd;
            val_q      <= req_i.value;
            res_val_q  <= '0;
            res_back_q <= '0;
            res_fi_q   <= (req_cmd == CMD_FIND) ? COUNT_W'(cnt_q) : '0;
            pend_q     <= 1'b0;
            case (req_cmd)
              CMD_PUSH_FRONT, CMD_PUSH_BACK, CMD_INSERT: begin
                if (full) begin
                  res_st_q <= STAT_FULL;
                  state_q  <= S_FINISH;
                end else begin
                  res_st_q <= STAT_OK;
                  tpos_q   <= ins_pos;
                  idx_q    <= last_idx;
                  dir_up_q <= 1'b1;
                  state_q  <= (CNT_W'(ins_pos) == cnt_q) ? S_INS_WR : S_SHIFT;
                end
              end
              CMD_POP_FRONT, CMD_POP_BACK: begin
                if (empty) begin
                  res_st_q <= STAT_EMPTY;
                  state_q  <= S_FINISH;
                end else begin
                  res_st_q <= STAT_OK;
                  tpos_q   <= (req_cmd == CMD_POP_FRONT) ? '0 : last_idx;
                  state_q  <= S_TAKE_RD;
                end
              end
              CMD_REMOVE: begin
                if (!pos_in_range) begin
                  res_st_q <= STAT_RANGE;
                  state_q  <= S_FINISH;
                end else begin
                  res_st_q <= STAT_OK;
                  tpos_q   <= IDX_W'(req_i.position);
                  state_q  <= S_TAKE_RD;
                end
              end
              CMD_FIND: begin
                res_st_q <= STAT_NOTFOUND;
                idx_q    <= '0;
                if (empty) begin
                  state_q <= S_FINISH;
                end else begin
                  state_q <= S_FIND;
                end
              end
              CMD_CLEAR: begin
                res_st_q <= STAT_OK;
                cnt_q    <= '0;
                state_q  <= S_FINISH;
              end
              CMD_READ_ENDS: begin
                if (empty) begin
                  res_st_q <= STAT_EMPTY;
                  state_q  <= S_FINISH;
                end else begin
                  res_st_q <= STAT_OK;
                  state_q  <= S_ENDS_A;
                end
              end
              default: begin
                res_st_q <= STAT_OK;
                state_q  <= S_FINISH;
              end
            endcase
          end
        end

        // one entry read per cycle, written one slot over in the next cycle
        S_SHIFT: begin
          pend_q      <= 1'b1;
          pend_addr_q <= dir_up_q ? IDX_W'(idx_q + 1'b1) : IDX_W'(idx_q - 1'b1);
          if (shift_last) begin
            state_q <= S_DRAIN;
          end else begin
            idx_q <= dir_up_q ? IDX_W'(idx_q - 1'b1) : IDX_W'(idx_q + 1'b1);
          end
        end

        S_DRAIN: begin
          pend_q <= 1'b0;
          if (dir_up_q) begin
            state_q <= S_INS_WR;
          end else begin
            cnt_q   <= cnt_q - CNT_W'(1);
            state_q <= S_FINISH;
          end
        end

        S_INS_WR: begin
          cnt_q   <= cnt_q + CNT_W'(1);
          state_q <= S_FINISH;
        end

        S_TAKE_RD: begin
          state_q <= S_TAKE_CAP;
        end

        S_TAKE_CAP: begin
          if (cmd_q != CMD_REMOVE) begin
            res_val_q <= rd_q;
          end
          if (tpos_q != last_idx) begin
            idx_q    <= IDX_W'(tpos_q + 1'b1);
            dir_up_q <= 1'b0;
            state_q  <= S_SHIFT;
          end else begin
            cnt_q   <= cnt_q - CNT_W'(1);
            state_q <= S_FINISH;
          end
        end

        // read ahead while comparing the word fetched in the previous cycle
        S_FIND: begin
          pend_addr_q <= idx_q;
          if (pend_q && (rd_q == val_q)) begin
            res_fi_q <= COUNT_W'(pend_addr_q);
            res_st_q <= STAT_OK;
            pend_q   <= 1'b0;
            state_q  <= S_FINISH;
          end else begin
            pend_q <= 1'b1;
            if (idx_q == last_idx) begin
              state_q <= S_FIND_LAST;
            end else begin
              idx_q <= IDX_W'(idx_q + 1'b1);
            end
          end
        end

        S_FIND_LAST: begin
          pend_q <= 1'b0;
          if (rd_q == val_q) begin
            res_fi_q <= COUNT_W'(pend_addr_q);
            res_st_q <= STAT_OK;
          end
          state_q <= S_FINISH;
        end

        S_ENDS_A: begin
          state_q <= S_ENDS_B;
        end

        S_ENDS_B: begin
          res_val_q <= rd_q;
          state_q   <= S_ENDS_C;
        end

        S_ENDS_C: begin
          res_back_q <= rd_q;
          state_q    <= S_FINISH;
        end

        S_FINISH: begin
          if (!out_valid_q || rsp_o.ready) begin
            out_valid_q <= 1'b1;
            out_val_q   <= res_val_q;
            out_back_q  <= res_back_q;
            out_fi_q    <= res_fi_q;
            out_st_q    <= res_st_q;
            out_cnt_q   <= COUNT_W'(cnt_q);
            state_q     <= S_IDLE;
          end
        end

        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign req_i.ready        = (state_q == S_IDLE);
  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.result_value = out_val_q;
  assign rsp_o.back_value   = out_back_q;
  assign rsp_o.found_index  = out_fi_q;
  assign rsp_o.status       = out_st_q;
  assign rsp_o.count        = out_cnt_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_pend_in_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> (state_q == S_SHIFT || state_q == S_DRAIN ||
                state_q == S_FIND || state_q == S_FIND_LAST))
    else $error("pending memory word outside a walk");

  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready && req_cmd == CMD_CLEAR) |=> (cnt_q == '0))
    else $error("clear left entries");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_st_q == STAT_FULL) |-> (out_cnt_q == COUNT_W'(CAPACITY)))
    else $error("full status with free room");

  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_st_q == STAT_EMPTY) |-> (out_cnt_q == '0))
    else $error("empty status with entries present");

endmodule
